@@ rtl/core/mlfq_pkg.sv @@
package mlfq_pkg;

   localparam int MAX_PROCS_DEF = 16;
   localparam int LEVELS_DEF    = 4;
   localparam int MAX_LEN_DEF   = 255;
   localparam int PID_W         = 4;
   localparam int LEN_W         = 8;
   localparam int LVL_W         = 2;
   localparam int QB_W          = 4;
   localparam int QUANT_W       = 7;
   localparam logic [QUANT_W-1:0] QUANT_MAX = 7'd127;

   localparam logic REQ_ARRIVE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [PID_W-1:0] arrive_pid;
      logic [LEN_W-1:0] arrive_length;
   } req_word_type;

   typedef struct packed {
      logic             ran_valid;
      logic [PID_W-1:0] ran_pid;
      logic [LVL_W-1:0] ran_level;
      logic             finished;
      logic             demoted;
      logic             preempted;
      logic [PID_W-1:0] preempted_pid;
      logic             rejected;
   } rsp_word_type;

   // Process record kept in the process table memory.
   typedef struct packed {
      logic [LVL_W-1:0]   level;
      logic [QUANT_W-1:0] quantum;
      logic [LEN_W-1:0]   instr;
   } proc_rec_type;

   // quantum_base << lvl, zero base read as one, saturated.
   function automatic logic [QUANT_W-1:0] level_quantum(input logic [QB_W-1:0] base,
                                                        input logic [LVL_W-1:0] lvl);
      logic [QB_W+8-1:0] q;
      logic [QB_W-1:0]   b;
      b = (base == '0) ? QB_W'(1) : base;
      q = {8'd0, b} << lvl;
      if (q > (QB_W+8)'(QUANT_MAX)) begin
         level_quantum = QUANT_MAX;
      end else begin
         level_quantum = q[QUANT_W-1:0];
      end
   endfunction

endpackage

@@ rtl/core/mlfq_queue_ram.sv @@
module mlfq_queue_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [mlfq_pkg::PID_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic [mlfq_pkg::PID_W-1:0] rd_data
);
   import mlfq_pkg::*;

   logic [PID_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/mlfq_proc_ram.sv @@
module mlfq_proc_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  mlfq_pkg::proc_rec_type      wr_data,
   input  logic [AW-1:0]               rd_addr,
   output mlfq_pkg::proc_rec_type      rd_data
);
   import mlfq_pkg::*;

   proc_rec_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/multilevel_feedback_queue_scheduler.sv @@
// Multilevel feedback queue scheduler, four priority levels by default.
// Input channel: drive req_word with start high while busy is low; the word is
// taken at that edge. An arrival word registers a process at level 0; a tick
// word runs one scheduling step (preempt, dispatch, run one instruction,
// retire or demote).
// Result channel: exactly one rsp_word per input word, marked by rsp_strobe
// for one cycle. The receiver cannot stall, so results are never held.
// Path: an arrival passes the arrival and done states; a tick passes the top
// state and goes to done when nothing can run, passes the record read and
// execute states when the running process keeps the CPU, and adds the pop and
// dispatch states when a dispatch occurs, with or without a preempt. The queue
// ring memory and the process table both have registered reads, and each
// queue pop or process record fetch costs a read turn. busy stays high until
// the result is out, so one word is in flight at a time.
// csr_wr_en/csr_wr_data write quantum_base; write only while idle.
// Reset: head, tail and count of every level, the active flags, the running
// process and the FSM clear at once. Ring and process memories are not
// cleared; no entry is read before it is written.
module multilevel_feedback_queue_scheduler #(
   parameter int MAX_PROCS = mlfq_pkg::MAX_PROCS_DEF,
   parameter int LEVELS    = mlfq_pkg::LEVELS_DEF,
   parameter int MAX_LEN   = mlfq_pkg::MAX_LEN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  mlfq_pkg::req_word_type    req_word,
   output logic                      rsp_strobe,
   output mlfq_pkg::rsp_word_type    rsp_word,
   input  logic                      csr_wr_en,
   input  logic [mlfq_pkg::QB_W-1:0] csr_wr_data
);
   import mlfq_pkg::*;

   localparam int PW = $clog2(MAX_PROCS);
   localparam int LW = $clog2(LEVELS);
   localparam int AW = PW + LW;
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam logic [LEN_W-1:0] LEN_CAP =
      (MAX_LEN >= 255) ? LEN_W'(255) : LEN_W'(MAX_LEN);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ARR   = 8'b0000_0010,  // arrival: write record and push
      ST_TOP   = 8'b0000_0100,  // tick: compare running level with top level
      ST_POP   = 8'b0000_1000,  // ring read data ready, fetch record
      ST_DISP  = 8'b0001_0000,  // record of dispatched process ready
      ST_RREAD = 8'b0010_0000,  // fetch record of running process
      ST_EXEC  = 8'b0100_0000,  // run one instruction
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [QB_W-1:0]  qbase_ff;
   logic [PW-1:0]    head_ff  [LEVELS];
   logic [PW-1:0]    tail_ff  [LEVELS];
   logic [CW-1:0]    count_ff [LEVELS];
   logic [MAX_PROCS-1:0] active_ff;
   logic [PW-1:0]    run_id_ff;
   logic             run_valid_ff;
   logic [LW-1:0]    run_lvl_ff;   // level of running process, mirrors record
   req_word_type     req_ff;
   rsp_word_type     rsp_ff, rsp_in;
   logic [LW-1:0]    pop_lvl_ff;

   // memory ports
   logic             q_we;
   logic [AW-1:0]    q_waddr, q_raddr;
   logic [PID_W-1:0] q_wdata, q_rdata;
   logic             p_we;
   logic [PW-1:0]    p_waddr, p_raddr;
   proc_rec_type     p_wdata, p_rdata;

   mlfq_queue_ram #(.DEPTH(LEVELS * MAX_PROCS), .AW(AW)) u_qram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata));

   mlfq_proc_ram #(.DEPTH(MAX_PROCS), .AW(PW)) u_pram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
      .rd_addr(p_raddr), .rd_data(p_rdata));

   // highest non-empty level
   logic          top_found;
   logic [LW-1:0] top_lvl;
   always_comb begin
      top_found = 1'b0;
      top_lvl   = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (count_ff[l] != '0) begin
            top_found = 1'b1;
            top_lvl   = LW'(l);
         end
      end
   end

   logic [PID_W-1:0] in_pid_ext;
   logic [PW-1:0]    arr_pid;
   logic             arr_bad;
   assign in_pid_ext = req_ff.arrive_pid;
   assign arr_pid    = PW'(in_pid_ext);
   assign arr_bad    = (32'(in_pid_ext) >= MAX_PROCS) || active_ff[arr_pid];

   // push and pop requests for the level bookkeeping
   logic          push_en, pop_en;
   logic [LW-1:0] push_lvl;
   logic [PW-1:0] push_pid;

   proc_rec_type  exec_rec;
   logic          exec_fin, exec_dem;
   logic [LW-1:0] dem_lvl;
   logic [QUANT_W-1:0] q_dec;

   always_comb begin
      exec_fin = (p_rdata.instr <= LEN_W'(1));
      q_dec    = (p_rdata.quantum != '0) ? p_rdata.quantum - 1'b1 : '0;
      exec_dem = !exec_fin && (q_dec == '0);
      dem_lvl  = (run_lvl_ff < LW'(LEVELS - 1)) ? run_lvl_ff + 1'b1 : run_lvl_ff;
      exec_rec = p_rdata;
      if (exec_fin) begin
         exec_rec.instr = '0;
      end else begin
         exec_rec.instr = p_rdata.instr - 1'b1;
         if (exec_dem) begin
            exec_rec.level   = LVL_W'(dem_lvl);
            exec_rec.quantum = level_quantum(qbase_ff, LVL_W'(dem_lvl));
         end else begin
            exec_rec.quantum = q_dec;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_in   = rsp_ff;
      q_raddr = {pop_lvl_ff, head_ff[pop_lvl_ff]};
      p_we = 1'b0; p_waddr = '0; p_wdata = '0;
      p_raddr = run_id_ff;
      push_en = 1'b0; push_lvl = '0; push_pid = '0;
      pop_en  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_in   = '0;
               state_in = (req_word.req_type == REQ_ARRIVE) ? ST_ARR : ST_TOP;
            end
         end
         ST_ARR: begin
            if (arr_bad) begin
               rsp_in.rejected = 1'b1;
            end else begin
               p_we    = 1'b1;
               p_waddr = arr_pid;
               p_wdata.level   = '0;
               p_wdata.quantum = level_quantum(qbase_ff, '0);
               p_wdata.instr   = (req_ff.arrive_length > LEN_CAP) ? LEN_CAP
                                                                 : req_ff.arrive_length;
               push_en  = 1'b1;
               push_lvl = '0;
               push_pid = arr_pid;
            end
            state_in = ST_DONE;
         end
         ST_TOP: begin
            // preempt keeps the record untouched; requeue at own level
            if (run_valid_ff && top_found && (top_lvl < run_lvl_ff)) begin
               push_en  = 1'b1;
               push_lvl = run_lvl_ff;
               push_pid = run_id_ff;
               rsp_in.preempted     = 1'b1;
               rsp_in.preempted_pid = PID_W'(run_id_ff);
               q_raddr  = {top_lvl, head_ff[top_lvl]};
               pop_en   = 1'b1;
               state_in = ST_POP;
            end else if (!run_valid_ff && top_found) begin
               q_raddr  = {top_lvl, head_ff[top_lvl]};
               pop_en   = 1'b1;
               state_in = ST_POP;
            end else if (run_valid_ff) begin
               state_in = ST_RREAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_POP: begin
            p_raddr  = PW'(q_rdata);
            state_in = ST_DISP;
         end
         ST_DISP: begin
            // dispatch: set level, reload an empty quantum
            p_we    = 1'b1;
            p_waddr = run_id_ff;
            p_wdata = p_rdata;
            p_wdata.level = LVL_W'(pop_lvl_ff);
            if (p_rdata.quantum == '0) begin
               p_wdata.quantum = level_quantum(qbase_ff, LVL_W'(pop_lvl_ff));
            end
            state_in = ST_RREAD;
         end
         ST_RREAD: begin
            p_raddr  = run_id_ff;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            p_we    = 1'b1;
            p_waddr = run_id_ff;
            p_wdata = exec_rec;
            rsp_in.ran_valid = 1'b1;
            rsp_in.ran_pid   = PID_W'(run_id_ff);
            rsp_in.ran_level = LVL_W'(run_lvl_ff);
            rsp_in.finished  = exec_fin;
            rsp_in.demoted   = exec_dem;
            if (exec_dem) begin
               push_en  = 1'b1;
               push_lvl = dem_lvl;
               push_pid = run_id_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);
   assign rsp_word   = rsp_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_word;
      end
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         qbase_ff     <= QB_W'(1);
         active_ff    <= '0;
         run_valid_ff <= 1'b0;
         run_id_ff    <= '0;
         run_lvl_ff   <= '0;
         pop_lvl_ff   <= '0;
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            qbase_ff <= csr_wr_data;
         end
         if (push_en) begin
            tail_ff[push_lvl] <= (tail_ff[push_lvl] == PW'(MAX_PROCS - 1)) ? '0
                                 : tail_ff[push_lvl] + 1'b1;
         end
         for (int l = 0; l < LEVELS; l++) begin
            if ((push_en && push_lvl == LW'(l)) && !(pop_en && top_lvl == LW'(l))) begin
               count_ff[l] <= count_ff[l] + 1'b1;
            end else if (!(push_en && push_lvl == LW'(l)) && (pop_en && top_lvl == LW'(l))) begin
               count_ff[l] <= count_ff[l] - 1'b1;
            end
         end
         if (pop_en) begin
            head_ff[top_lvl] <= (head_ff[top_lvl] == PW'(MAX_PROCS - 1)) ? '0
                                : head_ff[top_lvl] + 1'b1;
            pop_lvl_ff   <= top_lvl;
            run_lvl_ff   <= top_lvl;
            run_valid_ff <= 1'b1;
         end
         if (state_ff == ST_POP) begin
            run_id_ff <= PW'(q_rdata);
         end
         if (state_ff == ST_ARR && !arr_bad) begin
            active_ff[arr_pid] <= 1'b1;
         end
         if (state_ff == ST_EXEC) begin
            if (exec_fin) begin
               active_ff[run_id_ff] <= 1'b0;
               run_valid_ff <= 1'b0;
            end else if (exec_dem) begin
               run_valid_ff <= 1'b0;
               run_lvl_ff   <= dem_lvl;
            end
         end
      end
   end

   // ring write port follows push requests
   always_comb begin
      q_we    = push_en;
      q_waddr = {push_lvl, tail_ff[push_lvl]};
      q_wdata = PID_W'(push_pid);
   end

endmodule
